// ----- src/cll_pkg.sv -----
// ----------------------------------------------------------------------------
// cll_pkg: shared definitions for the cursor linked list engine
// Pool size, pointer types, request codes, sequencer states and the control
// bundle between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package cll_pkg;

   // node pool; a pointer has one more code than the pool for the null marker
   localparam int NODE_COUNT = 256;
   localparam int IDX_W      = $clog2(NODE_COUNT);
   localparam int PTR_W      = $clog2(NODE_COUNT + 1);
   localparam int WORD_W     = 32;
   localparam int OP_W       = 4;
   localparam int RSP_BITS   = 2 + 2 * WORD_W + 1;
   localparam int RSP_W      = ((RSP_BITS + 7) / 8) * 8;

   typedef logic [PTR_W-1:0]  ptr_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [WORD_W-1:0] word_type;

   localparam ptr_type NULL_PTR = ptr_type'(NODE_COUNT);

   // request codes
   typedef enum logic [OP_W-1:0] {
      OP_NONE      = 4'd0,
      OP_CLEAR     = 4'd1,
      OP_INS_HEAD  = 4'd2,
      OP_CUR_HEAD  = 4'd3,
      OP_DEL_HEAD  = 4'd4,
      OP_DEL_AFTER = 4'd5,
      OP_INS_AFTER = 4'd6,
      OP_OVERWRITE = 4'd7,
      OP_ADVANCE   = 4'd8
   } op_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_FIX  = 2'd2
   } state_type;

   // sequencer to datapath
   typedef struct packed {
      logic accept;    // item taken this cycle, memory read issued
      logic exec;      // read data valid, main update
      logic fix;       // second link write
      logic commit;    // state and memory updates take effect
      logic rsp_load;  // result register loads
   } ctl_type;

   // true for a pointer that names a node
   function automatic logic is_node(ptr_type p);
      return p < NULL_PTR;
   endfunction

endpackage

// ----- src/cll_node_mem.sv -----
// ----------------------------------------------------------------------------
// cll_node_mem: node pool storage
// Data and link arrays, one shared read address with registered read data,
// one write port on each array.
// ----------------------------------------------------------------------------
module cll_node_mem (
   input  logic              clock,
   input  logic              rd_en,
   input  cll_pkg::idx_type  rd_addr,
   output cll_pkg::word_type rd_data,
   output cll_pkg::ptr_type  rd_link,
   input  logic              data_we,
   input  cll_pkg::idx_type  data_waddr,
   input  cll_pkg::word_type data_wdata,
   input  logic              link_we,
   input  cll_pkg::idx_type  link_waddr,
   input  cll_pkg::ptr_type  link_wdata
);

   cll_pkg::word_type data_mem [cll_pkg::NODE_COUNT];
   cll_pkg::ptr_type  link_mem [cll_pkg::NODE_COUNT];

   cll_pkg::word_type rd_data_ff;
   cll_pkg::ptr_type  rd_link_ff;

   // data array
   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[data_waddr] <= data_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= data_mem[rd_addr];
      end
   end

   // link array
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (rd_en) begin
         rd_link_ff <= link_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign rd_link = rd_link_ff;

endmodule

// ----- src/cll_fsm.sv -----
// ----------------------------------------------------------------------------
// cll_fsm: request sequencer
// Accept with read, update with read data, optional second link write; the
// last step waits for the result register to be free.
// ----------------------------------------------------------------------------
module cll_fsm (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             need_fix,
   input  logic             slot_free,
   output logic             req_ready,
   output cll_pkg::ctl_type ctl
);

   cll_pkg::state_type state_ff;
   cll_pkg::state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cll_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = cll_pkg::ST_EXEC;
            end
         end
         cll_pkg::ST_EXEC: begin
            if (need_fix) begin
               state_in = cll_pkg::ST_FIX;
            end else if (slot_free) begin
               state_in = cll_pkg::ST_IDLE;
            end
         end
         cll_pkg::ST_FIX: begin
            if (slot_free) begin
               state_in = cll_pkg::ST_IDLE;
            end
         end
         default: state_in = cll_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         cll_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            ctl.accept = req_valid;
         end
         cll_pkg::ST_EXEC: begin
            ctl.exec     = 1'b1;
            ctl.commit   = need_fix || slot_free;
            ctl.rsp_load = !need_fix && slot_free;
         end
         cll_pkg::ST_FIX: begin
            ctl.fix      = 1'b1;
            ctl.commit   = slot_free;
            ctl.rsp_load = slot_free;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cll_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/cursor_linked_list_engine_core.sv -----
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_core: singly linked list with a cursor
// Node pool in block memory, head and cursor nodes mirrored in registers,
// one result item per request item.
// ----------------------------------------------------------------------------
// The accept step issues one node read; the update step then applies the
// read data and loads the result. Insert after cursor and delete after
// cursor add a second link write step, since they write two links and the
// link array has a single write port. The last step waits while a previous
// result has not been taken; a new request is accepted while a result waits.
// No clearing pass after reset: every node is written when it is allocated.
module cursor_linked_list_engine_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [cll_pkg::WORD_W-1:0]  req_tdata,   // [31:0] value
   input  logic [cll_pkg::OP_W-1:0]    req_tuser,   // [3:0] req_type
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [0] head_present, [32:1] head_value, [33] cursor_active,
   // [65:34] cursor_value, [66] status, rest zero
   output logic [cll_pkg::RSP_W-1:0]   rsp_tdata
);

   cll_pkg::ctl_type  ctl;
   logic              need_fix;
   logic              slot_free;

   // list registers
   cll_pkg::ptr_type  head_ff, head_in;
   cll_pkg::word_type head_data_ff, head_data_in;
   cll_pkg::ptr_type  head_link_ff, head_link_in;
   cll_pkg::ptr_type  cursor_ff, cursor_in;
   cll_pkg::word_type cursor_data_ff, cursor_data_in;
   cll_pkg::ptr_type  cursor_link_ff, cursor_link_in;
   cll_pkg::ptr_type  free_head_ff, free_head_in;
   cll_pkg::ptr_type  fresh_ff, fresh_in;
   cll_pkg::ptr_type  aux_ff, aux_in;
   logic              status_ff, status_in;

   // latched request
   cll_pkg::op_type   op_ff;
   cll_pkg::word_type value_ff;

   // memory ports
   cll_pkg::ptr_type  rd_ptr;
   cll_pkg::word_type rd_data;
   cll_pkg::ptr_type  rd_link;
   logic              data_we;
   cll_pkg::ptr_type  data_wptr;
   cll_pkg::word_type data_wdata;
   logic              link_we;
   cll_pkg::ptr_type  link_wptr;
   cll_pkg::ptr_type  link_wdata;

   // allocator
   logic              take_free;
   logic              take_ok;
   cll_pkg::ptr_type  take_n;

   // result register
   logic                      rsp_tvalid_ff;
   logic [cll_pkg::RSP_W-1:0] rsp_tdata_ff;
   logic [cll_pkg::RSP_W-1:0] rsp_tdata_in;
   logic                      head_pres;
   logic                      cursor_act;

   assign slot_free = !rsp_tvalid_ff || rsp_tready;

   cll_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .need_fix  (need_fix),
      .slot_free (slot_free),
      .req_ready (req_tready),
      .ctl       (ctl)
   );

   cll_node_mem u_mem (
      .clock      (clock),
      .rd_en      (ctl.accept),
      .rd_addr    (rd_ptr[cll_pkg::IDX_W-1:0]),
      .rd_data    (rd_data),
      .rd_link    (rd_link),
      .data_we    (data_we),
      .data_waddr (data_wptr[cll_pkg::IDX_W-1:0]),
      .data_wdata (data_wdata),
      .link_we    (link_we),
      .link_waddr (link_wptr[cll_pkg::IDX_W-1:0]),
      .link_wdata (link_wdata)
   );

   // read address at accept: the node the update will need
   always_comb begin
      unique case (cll_pkg::op_type'(req_tuser))
         cll_pkg::OP_INS_HEAD,
         cll_pkg::OP_INS_AFTER: rd_ptr = free_head_ff;
         cll_pkg::OP_DEL_HEAD:  rd_ptr = head_link_ff;
         default:               rd_ptr = cursor_link_ff;
      endcase
   end

   // node allocation: free list first, then never-used nodes
   assign take_free = cll_pkg::is_node(free_head_ff);
   assign take_ok   = take_free || (fresh_ff < cll_pkg::NULL_PTR);
   assign take_n    = take_free ? free_head_ff : fresh_ff;

   // second link write needed: delete after with a victim, insert after with a node
   assign need_fix =
      ((op_ff == cll_pkg::OP_DEL_AFTER) && cll_pkg::is_node(cursor_ff) &&
       cll_pkg::is_node(cursor_link_ff)) ||
      ((op_ff == cll_pkg::OP_INS_AFTER) && cll_pkg::is_node(cursor_ff) && take_ok);

   // update logic
   always_comb begin
      head_in        = head_ff;
      head_data_in   = head_data_ff;
      head_link_in   = head_link_ff;
      cursor_in      = cursor_ff;
      cursor_data_in = cursor_data_ff;
      cursor_link_in = cursor_link_ff;
      free_head_in   = free_head_ff;
      fresh_in       = fresh_ff;
      aux_in         = aux_ff;
      status_in      = status_ff;
      data_we        = 1'b0;
      data_wptr      = take_n;
      data_wdata     = value_ff;
      link_we        = 1'b0;
      link_wptr      = take_n;
      link_wdata     = head_ff;

      if (ctl.exec) begin
         status_in = 1'b0;
         unique case (op_ff)
            cll_pkg::OP_CLEAR: begin
               head_in      = cll_pkg::NULL_PTR;
               cursor_in    = cll_pkg::NULL_PTR;
               free_head_in = cll_pkg::NULL_PTR;
               fresh_in     = '0;
            end
            cll_pkg::OP_INS_HEAD: begin
               if (take_ok) begin
                  if (take_free) begin
                     free_head_in = rd_link;
                  end else begin
                     fresh_in = fresh_ff + cll_pkg::ptr_type'(1);
                  end
                  data_we      = 1'b1;
                  link_we      = 1'b1;
                  link_wdata   = head_ff;
                  head_in      = take_n;
                  head_data_in = value_ff;
                  head_link_in = head_ff;
               end else begin
                  status_in = 1'b1;
               end
            end
            cll_pkg::OP_CUR_HEAD: begin
               cursor_in      = head_ff;
               cursor_data_in = head_data_ff;
               cursor_link_in = head_link_ff;
            end
            cll_pkg::OP_DEL_HEAD: begin
               if (cursor_ff == head_ff) begin
                  cursor_in = cll_pkg::NULL_PTR;
               end
               if (cll_pkg::is_node(head_ff)) begin
                  head_in      = head_link_ff;
                  head_data_in = rd_data;
                  head_link_in = rd_link;
                  // old head goes to the free list
                  link_we      = 1'b1;
                  link_wptr    = head_ff;
                  link_wdata   = free_head_ff;
                  free_head_in = head_ff;
               end
            end
            cll_pkg::OP_DEL_AFTER: begin
               if (cll_pkg::is_node(cursor_ff) && cll_pkg::is_node(cursor_link_ff)) begin
                  // unlink victim now, free it in the fix step
                  link_we        = 1'b1;
                  link_wptr      = cursor_ff;
                  link_wdata     = rd_link;
                  cursor_link_in = rd_link;
                  if (head_ff == cursor_ff) begin
                     head_link_in = rd_link;
                  end
                  aux_in = cursor_link_ff;
               end
            end
            cll_pkg::OP_INS_AFTER: begin
               if (cll_pkg::is_node(cursor_ff)) begin
                  if (take_ok) begin
                     if (take_free) begin
                        free_head_in = rd_link;
                     end else begin
                        fresh_in = fresh_ff + cll_pkg::ptr_type'(1);
                     end
                     // new node now, cursor link in the fix step
                     data_we        = 1'b1;
                     link_we        = 1'b1;
                     link_wdata     = cursor_link_ff;
                     cursor_link_in = take_n;
                     if (head_ff == cursor_ff) begin
                        head_link_in = take_n;
                     end
                     aux_in = take_n;
                  end else begin
                     status_in = 1'b1;
                  end
               end
            end
            cll_pkg::OP_OVERWRITE: begin
               if (cll_pkg::is_node(cursor_ff)) begin
                  data_we        = 1'b1;
                  data_wptr      = cursor_ff;
                  cursor_data_in = value_ff;
                  if (head_ff == cursor_ff) begin
                     head_data_in = value_ff;
                  end
               end
            end
            cll_pkg::OP_ADVANCE: begin
               if (cll_pkg::is_node(cursor_ff)) begin
                  cursor_in      = cursor_link_ff;
                  cursor_data_in = rd_data;
                  cursor_link_in = rd_link;
               end
            end
            default: begin
               status_in = 1'b0;
            end
         endcase
      end else if (ctl.fix) begin
         unique case (op_ff)
            cll_pkg::OP_DEL_AFTER: begin
               link_we      = 1'b1;
               link_wptr    = aux_ff;
               link_wdata   = free_head_ff;
               free_head_in = aux_ff;
            end
            cll_pkg::OP_INS_AFTER: begin
               link_we    = 1'b1;
               link_wptr  = cursor_ff;
               link_wdata = aux_ff;
            end
            default: begin
               link_we = 1'b0;
            end
         endcase
      end

      // writes only take effect on commit
      data_we = data_we && ctl.commit;
      link_we = link_we && ctl.commit;
   end

   // result packing from the updated state
   assign head_pres  = cll_pkg::is_node(head_in);
   assign cursor_act = cll_pkg::is_node(cursor_in);

   always_comb begin
      rsp_tdata_in = '0;
      rsp_tdata_in[0] = head_pres;
      rsp_tdata_in[cll_pkg::WORD_W:1] = head_pres ? head_data_in : '0;
      rsp_tdata_in[cll_pkg::WORD_W+1] = cursor_act;
      rsp_tdata_in[2*cll_pkg::WORD_W+1:cll_pkg::WORD_W+2] =
         cursor_act ? cursor_data_in : '0;
      rsp_tdata_in[2*cll_pkg::WORD_W+2] = status_in;
   end

   // request latch
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         op_ff    <= cll_pkg::op_type'(req_tuser);
         value_ff <= req_tdata;
      end
   end

   // list control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= cll_pkg::NULL_PTR;
         cursor_ff    <= cll_pkg::NULL_PTR;
         free_head_ff <= cll_pkg::NULL_PTR;
         fresh_ff     <= '0;
      end else if (ctl.commit) begin
         head_ff      <= head_in;
         cursor_ff    <= cursor_in;
         free_head_ff <= free_head_in;
         fresh_ff     <= fresh_in;
      end
   end

   // mirrored head and cursor nodes, scratch
   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         head_data_ff   <= head_data_in;
         head_link_ff   <= head_link_in;
         cursor_data_ff <= cursor_data_in;
         cursor_link_ff <= cursor_link_in;
         aux_ff         <= aux_in;
         status_ff      <= status_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (ctl.rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_load) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
